### design/fxa_pkg.sv
`default_nettype none

package fxa_pkg;

    // Fraction bits of the fixed-point format (Q17.14)
    localparam int FRAC_BITS = 14;

    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        OP_RATIO     = 4'd0,
        OP_TO_INT_TR = 4'd1,
        OP_TO_INT_RN = 4'd2,
        OP_ADD       = 4'd3,
        OP_ADD_INT   = 4'd4,
        OP_SUB       = 4'd5,
        OP_SUB_INT   = 4'd6,
        OP_MUL       = 4'd7,
        OP_MUL_INT   = 4'd8,
        OP_DIV       = 4'd9,
        OP_DIV_INT   = 4'd10
    } fxa_op_t;

    // Side information that rides along the divider chain
    typedef struct packed {
        logic                is_div;
        logic                neg;
        logic                dz;
        logic [WORD_W-1:0]   alt;
    } fxa_side_t;

endpackage

`default_nettype wire

### design/fxa_req_if.sv
`default_nettype none

interface fxa_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b,
                    output ready);
endinterface

`default_nettype wire

### design/fxa_rsp_if.sv
`default_nettype none

interface fxa_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result;
    logic        div_by_zero;

    modport source (output valid, output result, output div_by_zero, input ready);
    modport sink   (input valid, input result, input div_by_zero, output ready);
endinterface

`default_nettype wire

### design/fxa_front.sv
`default_nettype none

// Two-stage front end: operand decode, simple ops, multiplier, divider setup.
module fxa_front #(
    parameter int FRAC_BITS = fxa_pkg::FRAC_BITS,
    parameter int DW        = fxa_pkg::WORD_W + FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [3:0]          in_op,
    input  wire logic signed [31:0]  in_a,
    input  wire logic signed [31:0]  in_b,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [DW-1:0]            out_dq,
    output logic [31:0]              out_dvsr,
    output fxa_pkg::fxa_side_t       out_side
);

    localparam logic [32:0] HALF  = 33'(1) << (FRAC_BITS - 1);
    localparam logic [31:0] FMASK = (32'(1) << FRAC_BITS) - 32'd1;

    typedef enum logic [1:0] {
        MODE_SIMPLE,
        MODE_MUL,
        MODE_MUL_INT
    } mode_t;

    // stage 1 registers
    logic               s1_valid_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        simple_reg;
    mode_t              mode_reg;
    logic [DW-1:0]      dvd_reg;
    logic [31:0]        dvsr_reg;
    logic               is_div_reg, neg_reg, dz_reg;

    // stage 2 registers
    logic               s2_valid_reg;
    logic [DW-1:0]      dq_reg;
    logic [31:0]        dvsr2_reg;
    fxa_pkg::fxa_side_t side_reg;

    logic               s1_ready, s2_ready;

    logic signed [63:0] prod_next;
    logic [31:0]        simple_next;
    mode_t              mode_next;
    logic [DW-1:0]      dvd_next;
    logic               is_div_next, neg_next, dz_next;

    logic               a_neg, b_neg, num_neg;
    logic [31:0]        mag_a, mag_b, mag_num, num;
    logic signed [31:0] tr_sum;
    logic signed [32:0] rn_sum;
    fxa_pkg::fxa_side_t side_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        a_neg   = in_a[31];
        b_neg   = in_b[31];
        num     = 32'(in_a) << FRAC_BITS;
        num_neg = num[31];
        mag_a   = a_neg ? (~in_a + 32'd1) : in_a;
        mag_b   = b_neg ? (~in_b + 32'd1) : in_b;
        mag_num = num_neg ? (~num + 32'd1) : num;

        // truncation toward zero: bias negatives by 2^F-1 before the shift
        tr_sum  = in_a + $signed(a_neg ? FMASK : 32'd0);
        // rounding: a+half or a-half, then truncate toward zero (folded bias)
        rn_sum  = $signed({in_a[31], in_a}) + $signed(a_neg ? (HALF - 33'd1) : HALF);

        prod_next   = 64'(in_a) * 64'(in_b);
        simple_next = '0;
        mode_next   = MODE_SIMPLE;
        dvd_next    = '0;
        is_div_next = 1'b0;
        neg_next    = 1'b0;

        unique case (fxa_pkg::fxa_op_t'(in_op))
            fxa_pkg::OP_RATIO:
            begin
                is_div_next = 1'b1;
                dvd_next    = DW'(mag_num);
                neg_next    = num_neg ^ b_neg;
            end
            fxa_pkg::OP_TO_INT_TR: simple_next = 32'(tr_sum >>> FRAC_BITS);
            fxa_pkg::OP_TO_INT_RN: simple_next = 32'(rn_sum >>> FRAC_BITS);
            fxa_pkg::OP_ADD:       simple_next = in_a + in_b;
            fxa_pkg::OP_ADD_INT:   simple_next = in_a + (in_b << FRAC_BITS);
            fxa_pkg::OP_SUB:       simple_next = in_a - in_b;
            fxa_pkg::OP_SUB_INT:   simple_next = in_a - (in_b << FRAC_BITS);
            fxa_pkg::OP_MUL:       mode_next = MODE_MUL;
            fxa_pkg::OP_MUL_INT:   mode_next = MODE_MUL_INT;
            fxa_pkg::OP_DIV:
            begin
                is_div_next = 1'b1;
                dvd_next    = DW'(mag_a) << FRAC_BITS;
                neg_next    = a_neg ^ b_neg;
            end
            fxa_pkg::OP_DIV_INT:
            begin
                is_div_next = 1'b1;
                dvd_next    = DW'(mag_a);
                neg_next    = a_neg ^ b_neg;
            end
            default: ;
        endcase

        dz_next = is_div_next && (in_b == 32'sd0);
    end

    always_comb
    begin
        side_next.is_div = is_div_reg;
        side_next.neg    = neg_reg;
        side_next.dz     = dz_reg;
        unique case (mode_reg)
            MODE_MUL:     side_next.alt = prod_reg[FRAC_BITS +: 32];
            MODE_MUL_INT: side_next.alt = prod_reg[31:0];
            default:      side_next.alt = simple_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            prod_reg   <= prod_next;
            simple_reg <= simple_next;
            mode_reg   <= mode_next;
            dvd_reg    <= dvd_next;
            dvsr_reg   <= mag_b;
            is_div_reg <= is_div_next;
            neg_reg    <= neg_next;
            dz_reg     <= dz_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            dq_reg    <= dvd_reg;
            dvsr2_reg <= dvsr_reg;
            side_reg  <= side_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_dq    = dq_reg;
    assign out_dvsr  = dvsr2_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### design/fxa_div_cell.sv
`default_nettype none

// One restoring-division step: one quotient bit per cell.
module fxa_div_cell #(
    parameter int DW = fxa_pkg::WORD_W + fxa_pkg::FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         in_rem,
    input  wire logic [DW-1:0]       in_dq,
    input  wire logic [31:0]         in_dvsr,
    input  wire fxa_pkg::fxa_side_t  in_side,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [31:0]              out_rem,
    output logic [DW-1:0]            out_dq,
    output logic [31:0]              out_dvsr,
    output fxa_pkg::fxa_side_t       out_side
);

    logic               valid_reg;
    logic [31:0]        rem_reg, rem_next;
    logic [DW-1:0]      dq_reg, dq_next;
    logic [31:0]        dvsr_reg;
    fxa_pkg::fxa_side_t side_reg;

    logic [32:0]        trial;
    logic               ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial    = {in_rem, in_dq[DW-1]};
        ge       = trial >= {1'b0, in_dvsr};
        rem_next = ge ? 32'(trial - {1'b0, in_dvsr}) : trial[31:0];
        dq_next  = {in_dq[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            dvsr_reg <= in_dvsr;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_dvsr  = dvsr_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### design/fixed_point_17_14_alu.sv
// Q17.14 fixed-point arithmetic unit.
// Request channel (req): op, operand_a, operand_b; a request is taken on a
// clock edge with valid and ready both high. Response channel (rsp): result
// and div_by_zero, one response per request, in request order.
// Structure: a two-stage front end (operand decode, add/sub/convert, one
// 32x32 multiplier with its product registered), then a chain of
// 32+FRAC_BITS division cells that each resolve one quotient bit, then an
// output register that applies the quotient sign and the zero-divisor rule.
// Every opcode takes the same path so responses leave in order.
// Response latency is set mostly by the length of the division chain.
// Throughput: one request per cycle while rsp.ready is high; every stage
// holds one request.
// Stalls: each stage advances when it is empty or its successor advances,
// so when rsp.ready is low the chain packs up behind the output register
// and req.ready falls only once every stage is full.
// Reset: rst_n clears all valid bits asynchronously; the data registers are
// not reset. Division by zero returns result 0 with div_by_zero set.
`default_nettype none

module fixed_point_17_14_alu #(
    parameter int FRAC_BITS = fxa_pkg::FRAC_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fxa_req_if.sink    req,
    fxa_rsp_if.source  rsp
);

    // dividend magnitude width: |a| * 2^FRAC_BITS
    localparam int DW = fxa_pkg::WORD_W + FRAC_BITS;

    logic               valid_c [0:DW];
    logic               ready_c [0:DW];
    logic [31:0]        rem_c   [0:DW];
    logic [DW-1:0]      dq_c    [0:DW];
    logic [31:0]        dvsr_c  [0:DW];
    fxa_pkg::fxa_side_t side_c  [0:DW];

    logic               out_valid_reg;
    logic [31:0]        result_reg, result_next;
    logic               dz_reg;
    logic [31:0]        quot;
    logic               take;

    fxa_front #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_op     (req.op),
        .in_a      (req.operand_a),
        .in_b      (req.operand_b),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_dq    (dq_c[0]),
        .out_dvsr  (dvsr_c[0]),
        .out_side  (side_c[0])
    );

    // partial remainder starts at zero
    assign rem_c[0] = '0;

    for (genvar k = 0; k < DW; k++)
    begin : g_cell
        fxa_div_cell #(
            .DW (DW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[k]),
            .in_ready  (ready_c[k]),
            .in_rem    (rem_c[k]),
            .in_dq     (dq_c[k]),
            .in_dvsr   (dvsr_c[k]),
            .in_side   (side_c[k]),
            .out_valid (valid_c[k+1]),
            .out_ready (ready_c[k+1]),
            .out_rem   (rem_c[k+1]),
            .out_dq    (dq_c[k+1]),
            .out_dvsr  (dvsr_c[k+1]),
            .out_side  (side_c[k+1])
        );
    end

    // output register
    assign ready_c[DW] = !out_valid_reg || rsp.ready;
    assign take        = ready_c[DW] && valid_c[DW];

    always_comb
    begin
        // quotient wraps to 32 bits; the sign is applied on the low word
        quot = dq_c[DW][31:0];
        priority if (side_c[DW].dz)
            result_next = '0;
        else if (side_c[DW].is_div)
            result_next = side_c[DW].neg ? (~quot + 32'd1) : quot;
        else
            result_next = side_c[DW].alt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready_c[DW])
            out_valid_reg <= valid_c[DW];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
            dz_reg     <= side_c[DW].dz;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result      = result_reg;
    assign rsp.div_by_zero = dz_reg;

endmodule

`default_nettype wire
